// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the command frame receiver checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define CFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("command frame receiver check failed");

// Next-cycle implication, switched off while reset is high.
`define CFR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("command frame receiver check failed");

// Next-cycle implication that also holds across reset.
`define CFR_ASSERT_ALWAYS_NXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("command frame receiver check failed");

`endif

// ===== rtl/cfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver package
// Types and constants shared by the frame receiver modules and its checker.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned COPY_COUNT = 4;
   localparam int unsigned COPY_IDX_W = $clog2(COPY_COUNT);

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h3C;
   localparam logic [BYTE_W-1:0] CRC_INIT  = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;

   // Position within the seven-word frame.
   typedef enum logic [2:0] {
      POS_HUNT  = 3'd0,
      POS_SYNC2 = 3'd1,
      POS_COPY0 = 3'd2,
      POS_COPY1 = 3'd3,
      POS_COPY2 = 3'd4,
      POS_COPY3 = 3'd5,
      POS_CHECK = 3'd6
   } pos_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED    = 2'd0,
      ST_NO_MAJORITY = 2'd1,
      ST_BAD_CRC     = 2'd2
   } status_type;

   typedef struct packed {
      logic              found;
      logic [BYTE_W-1:0] command;
   } vote_type;

   typedef struct packed {
      logic              valid;
      status_type        status;
      logic [BYTE_W-1:0] command;
   } frame_result_type;

endpackage

// ===== rtl/cfr_crc8.sv =====
// ----------------------------------------------------------------------------
// CRC-8 byte step
// Folds one byte into a running CRC-8, polynomial 0x07, MSB first.
// ----------------------------------------------------------------------------
module cfr_crc8 (
   input  logic [cfr_pkg::BYTE_W-1:0] crc_in,
   input  logic [cfr_pkg::BYTE_W-1:0] data_in,
   output logic [cfr_pkg::BYTE_W-1:0] crc_out
);

   logic [cfr_pkg::BYTE_W-1:0] work;

   always_comb begin
      work = crc_in ^ data_in;
      for (int k = 0; k < cfr_pkg::BYTE_W; k++) begin
         if (work[cfr_pkg::BYTE_W-1]) begin
            work = {work[cfr_pkg::BYTE_W-2:0], 1'b0} ^ cfr_pkg::CRC_POLY;
         end else begin
            work = {work[cfr_pkg::BYTE_W-2:0], 1'b0};
         end
      end
      crc_out = work;
   end

endmodule

// ===== rtl/cfr_vote.sv =====
// ----------------------------------------------------------------------------
// Command copy vote
// Picks the first equal pair among four command copies in fixed priority.
// ----------------------------------------------------------------------------
module cfr_vote (
   input  logic [cfr_pkg::BYTE_W-1:0] copies [cfr_pkg::COPY_COUNT],
   output cfr_pkg::vote_type          vote
);

   always_comb begin
      vote.found   = 1'b1;
      vote.command = copies[0];
      if (copies[0] == copies[1] || copies[0] == copies[2] || copies[0] == copies[3]) begin
         vote.command = copies[0];
      end else if (copies[1] == copies[2] || copies[1] == copies[3]) begin
         vote.command = copies[1];
      end else if (copies[2] == copies[3]) begin
         vote.command = copies[2];
      end else begin
         vote.found = 1'b0;
      end
   end

endmodule

// ===== rtl/cfr_frame_ctl.sv =====
// ----------------------------------------------------------------------------
// Frame tracker
// Follows the frame position, builds the CRC, stores the command copies and
// produces the verdict on the check word.
// ----------------------------------------------------------------------------
module cfr_frame_ctl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            word_valid,
   input  logic [cfr_pkg::BYTE_W-1:0]      word,
   output cfr_pkg::frame_result_type       result
);

   cfr_pkg::pos_type                pos_ff, pos_in;
   logic [cfr_pkg::BYTE_W-1:0]      crc_ff, crc_in;
   logic [cfr_pkg::BYTE_W-1:0]      last_ff, last_in;
   logic [cfr_pkg::BYTE_W-1:0]      copies_ff [cfr_pkg::COPY_COUNT];
   logic [cfr_pkg::BYTE_W-1:0]      crc_step;
   logic                            copy_we;
   logic [cfr_pkg::COPY_IDX_W-1:0]  copy_idx;
   cfr_pkg::vote_type               vote;

   cfr_crc8 u_crc8 (
      .crc_in  (crc_ff),
      .data_in (word),
      .crc_out (crc_step)
   );

   cfr_vote u_vote (
      .copies (copies_ff),
      .vote   (vote)
   );

   // Next position and running CRC.
   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      case (pos_ff)
         cfr_pkg::POS_SYNC2: begin
            if (word == cfr_pkg::SYNC_BYTE) begin
               pos_in = cfr_pkg::POS_COPY0;
               crc_in = crc_step;
            end else begin
               pos_in = cfr_pkg::POS_HUNT;
               crc_in = cfr_pkg::CRC_INIT;
            end
         end
         cfr_pkg::POS_COPY0: begin
            pos_in = cfr_pkg::POS_COPY1;
            crc_in = crc_step;
         end
         cfr_pkg::POS_COPY1: begin
            pos_in = cfr_pkg::POS_COPY2;
            crc_in = crc_step;
         end
         cfr_pkg::POS_COPY2: begin
            pos_in = cfr_pkg::POS_COPY3;
            crc_in = crc_step;
         end
         cfr_pkg::POS_COPY3: begin
            pos_in = cfr_pkg::POS_CHECK;
            crc_in = crc_step;
         end
         cfr_pkg::POS_CHECK: begin
            pos_in = cfr_pkg::POS_HUNT;
            crc_in = cfr_pkg::CRC_INIT;
         end
         default: begin
            // Hunting: the CRC always sits at its initial value here.
            if (word == cfr_pkg::SYNC_BYTE) begin
               pos_in = cfr_pkg::POS_SYNC2;
               crc_in = crc_step;
            end else begin
               pos_in = cfr_pkg::POS_HUNT;
               crc_in = cfr_pkg::CRC_INIT;
            end
         end
      endcase
   end

   // Copy writes and the verdict on the check word.
   always_comb begin
      copy_we        = 1'b0;
      copy_idx       = '0;
      last_in        = last_ff;
      result.valid   = 1'b0;
      result.status  = cfr_pkg::ST_ACCEPTED;
      result.command = last_ff;
      case (pos_ff)
         cfr_pkg::POS_COPY0: begin
            copy_we  = 1'b1;
            copy_idx = cfr_pkg::COPY_IDX_W'(0);
         end
         cfr_pkg::POS_COPY1: begin
            copy_we  = 1'b1;
            copy_idx = cfr_pkg::COPY_IDX_W'(1);
         end
         cfr_pkg::POS_COPY2: begin
            copy_we  = 1'b1;
            copy_idx = cfr_pkg::COPY_IDX_W'(2);
         end
         cfr_pkg::POS_COPY3: begin
            copy_we  = 1'b1;
            copy_idx = cfr_pkg::COPY_IDX_W'(3);
         end
         cfr_pkg::POS_CHECK: begin
            result.valid = word_valid;
            if (!vote.found) begin
               result.status = cfr_pkg::ST_NO_MAJORITY;
            end else if (word != crc_ff) begin
               result.status = cfr_pkg::ST_BAD_CRC;
            end else begin
               result.status  = cfr_pkg::ST_ACCEPTED;
               result.command = vote.command;
               last_in        = vote.command;
            end
         end
         default: begin
            copy_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= cfr_pkg::POS_HUNT;
         crc_ff  <= cfr_pkg::CRC_INIT;
         last_ff <= '0;
      end else if (word_valid) begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_valid && copy_we) begin
         copies_ff[copy_idx] <= word;
      end
   end

endmodule

// ===== rtl/command_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver
// Takes received bytes on the req_ stream and hunts for seven-word frames:
// two sync words 0x3C, four command copies and a CRC-8 word (poly 0x07,
// init 0xFF, over the first six words). Each completed frame gives one word
// on the rsp_ stream: the status in rsp_tuser and the held command in
// rsp_tdata. Words outside a frame, and a bad second sync word, give nothing.
// An accepted req word waits in the input register; when that register
// drains, the CRC step and the vote settle into the result register, which
// drives rsp_tvalid. A word is accepted in every cycle unless a stalled
// result keeps the input register full; the input register drains whenever
// the result register is empty or taken. When the consumer holds rsp_tready
// low, the result stays put, the input register keeps its word and req_tready
// falls until the result is taken. Reset empties both registers, restarts the
// sync hunt with the CRC at 0xFF and clears the held command to zero.
// ----------------------------------------------------------------------------
module command_frame_receiver (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] held_command
   output logic [1:0] rsp_tuser    // [1:0] frame_status
);

   logic                        in_valid_ff, in_valid_in;
   logic [cfr_pkg::BYTE_W-1:0]  in_word_ff;
   logic                        out_valid_ff, out_valid_in;
   cfr_pkg::status_type         out_status_ff;
   logic [cfr_pkg::BYTE_W-1:0]  out_command_ff;
   logic                        advance;
   logic                        req_accept;
   cfr_pkg::frame_result_type   result;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff && result.valid;
      end
   end

   cfr_frame_ctl u_frame_ctl (
      .clock      (clock),
      .reset      (reset),
      .word_valid (in_valid_ff && advance),
      .word       (in_word_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_tdata;
      end
      if (advance && in_valid_ff && result.valid) begin
         out_status_ff  <= result.status;
         out_command_ff <= result.command;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_command_ff;
   assign rsp_tuser  = out_status_ff;

endmodule

// ===== rtl/cfr_checker.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver checker
// Port-level checks on the stream handshakes and the reported status.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser
);

   logic       rsp_stall;
   logic [9:0] rsp_word;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tuser, rsp_tdata};

   // Only a stalled result may hold back the input side.
   `CFR_ASSERT_IMP(a_stall_source, clock, reset, !req_tready, rsp_stall)

   `CFR_ASSERT_IMP(a_status_code, clock, reset, rsp_tvalid, rsp_tuser <= cfr_pkg::ST_BAD_CRC)

   `CFR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   `CFR_ASSERT_ALWAYS_NXT(a_reset_empty, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/tb_command_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Command frame receiver testbench
// Drives received bytes into the block and checks every frame result against
// a predictor of the sync hunt, the running CRC-8 and the four-copy vote. A
// short directed table covers dropped bytes, a bad second sync word, an
// accepted frame, a frame without majority and a checksum failure. Random
// frames, broken frames and noise follow under three idling phases, with one
// long hold-off on the result side and a drain pause before each later phase.
// ----------------------------------------------------------------------------
module tb_command_frame_receiver;
   timeunit 1ns;
   timeprecision 1ps;

   // How a directed row forms its byte: as written, or from the running CRC.
   typedef enum logic [1:0] {
      BK_LITERAL   = 2'd0,
      BK_CRC       = 2'd1,
      BK_CRC_WRONG = 2'd2
   } byte_kind_type;

   typedef struct packed {
      byte_kind_type       kind;
      logic [7:0]          data;
      logic                typed;
      cfr_pkg::status_type status;
      logic [7:0]          command;
   } stim_row_type;

   typedef struct packed {
      cfr_pkg::status_type status;
      logic [7:0]          command;
   } frame_word_type;

   localparam int DIRECTED_ROWS = 25;
   localparam int HOLD_CYCLES   = 64;
   localparam int PHASE_END [3] = '{420, 840, 1260};

   // Expected results are typed in only where they follow at a glance.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{BK_LITERAL,   8'h00, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'hFF, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h3C, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h7E, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h3C, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h3C, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h01, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h02, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h04, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h08, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'hFF, 1'b1, cfr_pkg::ST_NO_MAJORITY, 8'h00},
      '{BK_LITERAL,   8'h3C, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h3C, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'hFF, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'hFF, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'hFF, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'hFF, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_CRC,       8'h00, 1'b1, cfr_pkg::ST_ACCEPTED,    8'hFF},
      '{BK_LITERAL,   8'h3C, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h3C, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h00, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h00, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h00, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_LITERAL,   8'h00, 1'b0, cfr_pkg::ST_ACCEPTED,    8'h00},
      '{BK_CRC_WRONG, 8'h00, 1'b1, cfr_pkg::ST_BAD_CRC,     8'hFF}
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] rx_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] held_command
   logic [1:0] rsp_tuser;            // [1:0] frame_status

   // Predictor state.
   cfr_pkg::pos_type rx_pos = cfr_pkg::POS_HUNT;
   logic [7:0] rx_crc     = cfr_pkg::CRC_INIT;
   logic [7:0] rx_copies [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
   logic [7:0] rx_last    = 8'h00;

   frame_word_type pending_frames [$];
   int words_sent    = 0;
   int mismatches    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   command_frame_receiver i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         v = v[7] ? ((v << 1) ^ cfr_pkg::CRC_POLY) : (v << 1);
      end
      return v;
   endfunction

   // Advances the frame state by one byte; returns 1 when a frame completes.
   function automatic logic predict_frame(input logic [7:0] b, output frame_word_type res);
      logic       found;
      logic [7:0] cmd;
      found = 1'b0;
      cmd   = 8'h00;
      res   = '0;
      predict_frame = 1'b0;
      case (rx_pos)
         cfr_pkg::POS_SYNC2: begin
            if (b != cfr_pkg::SYNC_BYTE) begin
               rx_pos = cfr_pkg::POS_HUNT;
               rx_crc = cfr_pkg::CRC_INIT;
            end else begin
               rx_crc = crc8_next(rx_crc, b);
               rx_pos = cfr_pkg::POS_COPY0;
            end
         end
         cfr_pkg::POS_COPY0, cfr_pkg::POS_COPY1,
         cfr_pkg::POS_COPY2, cfr_pkg::POS_COPY3: begin
            rx_copies[rx_pos - cfr_pkg::POS_COPY0] = b;
            rx_crc = crc8_next(rx_crc, b);
            rx_pos = cfr_pkg::pos_type'(rx_pos + 3'd1);
         end
         cfr_pkg::POS_CHECK: begin
            for (int i = 0; i < 4; i++) begin
               for (int j = i + 1; j < 4; j++) begin
                  if (!found && rx_copies[i] == rx_copies[j]) begin
                     found = 1'b1;
                     cmd   = rx_copies[i];
                  end
               end
            end
            if (!found) begin
               res.status = cfr_pkg::ST_NO_MAJORITY;
            end else if (b != rx_crc) begin
               res.status = cfr_pkg::ST_BAD_CRC;
            end else begin
               res.status = cfr_pkg::ST_ACCEPTED;
               rx_last    = cmd;
            end
            res.command   = rx_last;
            rx_pos        = cfr_pkg::POS_HUNT;
            rx_crc        = cfr_pkg::CRC_INIT;
            predict_frame = 1'b1;
         end
         default: begin
            // Hunting; the unused position code behaves the same way.
            rx_pos = cfr_pkg::POS_HUNT;
            rx_crc = cfr_pkg::CRC_INIT;
            if (b == cfr_pkg::SYNC_BYTE) begin
               rx_crc = crc8_next(cfr_pkg::CRC_INIT, b);
               rx_pos = cfr_pkg::POS_SYNC2;
            end
         end
      endcase
   endfunction

   // Offers one word, waits for it to be taken, then records what it should give.
   task automatic send_word(input logic [7:0] b, input logic typed,
                            input cfr_pkg::status_type status, input logic [7:0] command);
      frame_word_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (predict_frame(b, res)) begin
         if (typed) begin
            res.status  = status;
            res.command = command;
         end
         pending_frames.push_back(res);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_frames.size() != 0);
   endtask

   function automatic logic [7:0] pick_command();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return cfr_pkg::SYNC_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly well-formed frames with random content, the rest noise and
   // frames that break off early.
   task automatic send_random_burst();
      logic [7:0] copies [4];
      logic [7:0] cmd;
      int         shape;
      int         pair_a;
      int         pair_b;
      shape = $urandom_range(99);
      if (shape < 10) begin
         send_word(8'($urandom_range(255)), 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
      end else if (shape < 18) begin
         send_word(cfr_pkg::SYNC_BYTE, 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         send_word(8'($urandom_range(255)), 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
      end else if (shape < 25) begin
         send_word(cfr_pkg::SYNC_BYTE, 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         send_word(cfr_pkg::SYNC_BYTE, 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         repeat ($urandom_range(1, 4)) begin
            send_word(pick_command(), 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         end
      end else begin
         cmd = pick_command();
         for (int i = 0; i < 4; i++) copies[i] = pick_command();
         case ($urandom_range(7))
            0: begin pair_a = 0; pair_b = 1; end
            1: begin pair_a = 0; pair_b = 2; end
            2: begin pair_a = 0; pair_b = 3; end
            3: begin pair_a = 1; pair_b = 2; end
            4: begin pair_a = 1; pair_b = 3; end
            5: begin pair_a = 2; pair_b = 3; end
            6: begin
               pair_a = 0;
               pair_b = 0;
               for (int i = 0; i < 4; i++) copies[i] = cmd;
            end
            default: begin pair_a = 0; pair_b = 0; end
         endcase
         if (pair_a != pair_b) begin
            copies[pair_a] = cmd;
            copies[pair_b] = cmd;
         end
         send_word(cfr_pkg::SYNC_BYTE, 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         send_word(cfr_pkg::SYNC_BYTE, 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         for (int i = 0; i < 4; i++) send_word(copies[i], 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         if ($urandom_range(99) < 75 && rx_pos == cfr_pkg::POS_CHECK) begin
            send_word(rx_crc, 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         end else begin
            send_word(8'($urandom_range(255)), 1'b0, cfr_pkg::ST_ACCEPTED, 8'h00);
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatches < 10) $display("%0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Result side: random stalls, plus one long hold-off when asked for.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      frame_word_type exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d command %02h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            exp_word = pending_frames.pop_front();
            if (rsp_tuser !== exp_word.status || rsp_tdata !== exp_word.command) begin
               report_mismatch($sformatf(
                  "result mismatch: status %0d command %02h, expected %0d %02h",
                  rsp_tuser, rsp_tdata, exp_word.status, exp_word.command));
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      logic [7:0]   b;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 36;
      recv_idle_pct = 46;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = DIRECTED[r];
         case (row.kind)
            BK_CRC:       b = rx_crc;
            BK_CRC_WRONG: b = rx_crc ^ 8'h01;
            default:      b = row.data;
         endcase
         send_word(b, row.typed, row.status, row.command);
      end
      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 46;
            recv_idle_pct = 36;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // The sender pauses here until every frame result has arrived.
         if (ph != 0) wait_drained();
         if (ph == 2) hold_requests++;
         while (words_sent < PHASE_END[ph]) send_random_burst();
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cfr_pkg.sv
rtl/cfr_crc8.sv
rtl/cfr_vote.sv
rtl/cfr_frame_ctl.sv
rtl/command_frame_receiver.sv
rtl/cfr_checker.sv
tb/sv/tb_command_frame_receiver.sv
